/* src/tlpl_pkg.sv */
package tlpl_pkg;

  localparam int ID_W           = 7;
  localparam int NUM_IDS        = 128;
  localparam int LUT_IDX_W      = 10;
  localparam int MAX_LEAVES_DEF = 64;
  localparam int UPC_W          = 4;

  localparam logic [ID_W-1:0] LC_RESET = 7'd2;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACC,
    C_QUERY,
    C_X_ROOT,
    C_N_BOUND,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    XS_HOLD,
    XS_A,
    XS_B,
    XS_RDATA
  } x_sel_t;

  typedef enum logic [1:0] {
    RAM_READ,
    RAM_WR_L,
    RAM_WR_R
  } ram_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_ERR
  } res_op_t;

  typedef struct packed {
    logic             accept;
    ram_op_t          ram_op;
    x_sel_t           x_sel;
    logic             v_clr;
    logic             n_clr;
    logic             n_inc;
    logic             lb_ld;
    logic             pos_wr;
    logic             hit_ld;
    logic             cmp;
    res_op_t          res_op;
    logic             out_ld;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] U_DISP  = 4'd1;
  localparam logic [UPC_W-1:0] U_WR1   = 4'd2;
  localparam logic [UPC_W-1:0] U_WR2   = 4'd3;
  localparam logic [UPC_W-1:0] U_BLD   = 4'd4;
  localparam logic [UPC_W-1:0] U_BCHK  = 4'd5;
  localparam logic [UPC_W-1:0] U_BBND  = 4'd6;
  localparam logic [UPC_W-1:0] U_BSTEP = 4'd7;
  localparam logic [UPC_W-1:0] U_ALD   = 4'd8;
  localparam logic [UPC_W-1:0] U_ACHK  = 4'd9;
  localparam logic [UPC_W-1:0] U_ABND  = 4'd10;
  localparam logic [UPC_W-1:0] U_ASTEP = 4'd11;
  localparam logic [UPC_W-1:0] U_ACMP  = 4'd12;
  localparam logic [UPC_W-1:0] U_FIN   = 4'd13;
  localparam logic [UPC_W-1:0] U_ERR   = 4'd14;
  localparam logic [UPC_W-1:0] U_OUT   = 4'd15;

  // microprogram ROM; a false condition falls through to the next step
  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      U_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_NO_ACC;
        w.target = U_IDLE;
      end
      U_DISP: begin
        w.cond   = C_QUERY;
        w.target = U_BLD;
      end
      U_WR1: begin
        w.ram_op = RAM_WR_L;
      end
      U_WR2: begin
        w.ram_op = RAM_WR_R;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_BLD: begin
        w.x_sel = XS_B;
        w.n_clr = 1'b1;
        w.v_clr = 1'b1;
      end
      U_BCHK: begin
        w.cond   = C_X_ROOT;
        w.target = U_ALD;
      end
      U_BBND: begin
        w.cond   = C_N_BOUND;
        w.target = U_ERR;
      end
      U_BSTEP: begin
        w.x_sel  = XS_RDATA;
        w.pos_wr = 1'b1;
        w.n_inc  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_BCHK;
      end
      U_ALD: begin
        w.lb_ld = 1'b1;
        w.x_sel = XS_A;
        w.n_clr = 1'b1;
      end
      U_ACHK: begin
        w.cond   = C_X_ROOT;
        w.target = U_FIN;
      end
      U_ABND: begin
        w.cond   = C_N_BOUND;
        w.target = U_ERR;
      end
      U_ASTEP: begin
        w.x_sel  = XS_RDATA;
        w.hit_ld = 1'b1;
      end
      U_ACMP: begin
        w.cmp    = 1'b1;
        w.n_inc  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_ACHK;
      end
      U_FIN: begin
        w.res_op = RES_OK;
        w.cond   = C_ALWAYS;
        w.target = U_OUT;
      end
      U_ERR: begin
        w.res_op = RES_ERR;
      end
      U_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = U_OUT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // id -> table row, ids wrap modulo the table depth
  function automatic logic [NUM_IDS*LUT_IDX_W-1:0] mod_lut(input int unsigned depth);
    logic [NUM_IDS*LUT_IDX_W-1:0] r;
    int unsigned                  v;
    r = '0;
    for (int id = 0; id < NUM_IDS; id++) begin
      v = id;
      while (v >= depth) begin
        v = v - depth;
      end
      r[id*LUT_IDX_W +: LUT_IDX_W] = v[LUT_IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/tree_leaf_path_length.sv */
// Leaf-to-leaf path length in a rooted binary tree held as a parent table
// (2*MAX_LEAVES rows, ids wrap modulo that depth). A request with tuser 0
// records node_id as parent of both children; a request with
// tuser 1 walks leaf_b then leaf_a up to the root and returns the number of
// internal nodes between them, whether their lowest common ancestor is the
// root, and an error flag if a walk runs past 2*leaf_count-1 steps.
// A query is run by the microcoded sequencer stepping through the
// single-read-port parent table and the position table. One request is in
// work at a time; a new one is accepted while the previous result still
// waits at the output. leaf_count is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle; the block does not enforce it.
module tree_leaf_path_length #(
  parameter int MAX_LEAVES = tlpl_pkg::MAX_LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // leaf_count

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // node_id, left_child, right_child, leaf_a, leaf_b
  input  logic        in_tuser,      // req_type

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // path_internal_nodes, ancestor_is_root
  output logic        out_tuser      // walk_error
);

  localparam int TDEPTH = 2 * MAX_LEAVES;
  localparam int AW     = $clog2(TDEPTH);
  localparam int NW     = (MAX_LEAVES >= 128) ? 8 : $clog2(TDEPTH);
  localparam int CNTW   = NW + 1;
  localparam int IW     = tlpl_pkg::ID_W;
  localparam logic [IW-1:0] LC_CAP = (MAX_LEAVES > 127) ? 7'd127 : IW'(MAX_LEAVES);
  localparam logic [tlpl_pkg::NUM_IDS*tlpl_pkg::LUT_IDX_W-1:0] MOD_LUT =
    tlpl_pkg::mod_lut(TDEPTH);

  function automatic logic [AW-1:0] tbl_idx(input logic [IW-1:0] id);
    return MOD_LUT[int'(id)*tlpl_pkg::LUT_IDX_W +: AW];
  endfunction

  function automatic logic [6:0] sat7(input logic [CNTW-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return (w > 16'd127) ? 7'd127 : w[6:0];
  endfunction

  tlpl_pkg::uword_t uw;

  logic [tlpl_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic [IW-1:0]  lc_r;
  logic [IW-1:0]  lc_eff;
  logic [7:0]     root;
  logic [7:0]     bound;

  logic           req_type_r;
  logic [IW-1:0]  node_r, left_r, right_r, a_r, b_r;
  logic [IW-1:0]  x_r, x_nxt;
  logic [NW-1:0]  n_r, lb_r;
  logic           found_r, hit_r;
  logic [CNTW-1:0] count_r;
  logic [tlpl_pkg::NUM_IDS-1:0] valid_r;

  logic [6:0]     res_cnt_r;
  logic           res_root_r, res_err_r;
  logic           out_tvalid_r;
  logic [7:0]     out_tdata_r;
  logic           out_tuser_r;

  logic           in_acc;
  logic           cond_true;
  logic           out_free;
  logic           rd_is_root;

  logic           par_we;
  logic [AW-1:0]  par_waddr;
  logic [IW-1:0]  par_rdata;
  logic           pos_we;
  logic [NW-1:0]  pos_rdata;

  logic [CNTW-1:0] chain_sum;
  logic [CNTW-1:0] hit_cnt;

  assign uw        = tlpl_pkg::ucode(upc_r);
  assign in_tready = uw.accept;
  assign in_acc    = in_tvalid && uw.accept;
  assign out_free  = !out_tvalid_r || out_tready;

  assign lc_eff = (lc_r < 7'd2) ? 7'd2 : ((lc_r > LC_CAP) ? LC_CAP : lc_r);
  assign root   = {1'b0, lc_eff} + 8'd1;
  assign bound  = {lc_eff, 1'b0} - 8'd1;

  assign rd_is_root = ({1'b0, par_rdata} == root);

  always_comb begin
    case (uw.cond)
      tlpl_pkg::C_NEVER:    cond_true = 1'b0;
      tlpl_pkg::C_ALWAYS:   cond_true = 1'b1;
      tlpl_pkg::C_NO_ACC:   cond_true = !in_acc;
      tlpl_pkg::C_QUERY:    cond_true = req_type_r;
      tlpl_pkg::C_X_ROOT:   cond_true = ({1'b0, x_r} == root);
      tlpl_pkg::C_N_BOUND:  cond_true = (8'(n_r) >= bound);
      tlpl_pkg::C_OUT_BUSY: cond_true = !out_free;
      default:              cond_true = 1'b1;
    endcase
    upc_nxt = cond_true ? uw.target : upc_r + 1'b1;
  end

  always_comb begin
    case (uw.x_sel)
      tlpl_pkg::XS_A:     x_nxt = a_r;
      tlpl_pkg::XS_B:     x_nxt = b_r;
      tlpl_pkg::XS_RDATA: x_nxt = par_rdata;
      default:            x_nxt = x_r;
    endcase
  end

  // parent table
  assign par_we    = (uw.ram_op != tlpl_pkg::RAM_READ);
  assign par_waddr = (uw.ram_op == tlpl_pkg::RAM_WR_L) ? tbl_idx(left_r) : tbl_idx(right_r);

  tlpl_ram #(
    .WIDTH (IW),
    .DEPTH (TDEPTH)
  ) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (node_r),
    .raddr (tbl_idx(x_r)),
    .rdata (par_rdata)
  );

  // position of each node in leaf_b's chain
  assign pos_we = uw.pos_wr && !rd_is_root;

  tlpl_ram #(
    .WIDTH (NW),
    .DEPTH (tlpl_pkg::NUM_IDS)
  ) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (par_rdata),
    .wdata (n_r),
    .raddr (par_rdata),
    .rdata (pos_rdata)
  );

  assign hit_cnt   = CNTW'(n_r) + CNTW'(pos_rdata) + CNTW'(1);
  assign chain_sum = CNTW'(n_r) + CNTW'(lb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= tlpl_pkg::U_IDLE;
      lc_r         <= tlpl_pkg::LC_RESET;
      valid_r      <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (cfg_wr_en) begin
        lc_r <= cfg_wr_data;
      end
      if (uw.v_clr) begin
        valid_r <= '0;
      end else if (pos_we) begin
        valid_r[par_rdata] <= 1'b1;
      end
      if (uw.lb_ld) begin
        found_r <= 1'b0;
      end else if (uw.cmp && hit_r && !found_r) begin
        found_r <= 1'b1;
      end
      if (uw.out_ld && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r <= in_tuser;
      node_r     <= in_tdata[6:0];
      left_r     <= in_tdata[13:7];
      right_r    <= in_tdata[20:14];
      a_r        <= in_tdata[27:21];
      b_r        <= in_tdata[34:28];
    end
    x_r <= x_nxt;
    if (uw.n_clr) begin
      n_r <= '0;
    end else if (uw.n_inc) begin
      n_r <= n_r + 1'b1;
    end
    if (uw.lb_ld) begin
      lb_r <= n_r;
    end
    if (uw.hit_ld) begin
      hit_r <= valid_r[par_rdata] && !rd_is_root;
    end
    if (uw.cmp && hit_r && !found_r) begin
      count_r <= hit_cnt;
    end
    case (uw.res_op)
      tlpl_pkg::RES_OK: begin
        res_err_r <= 1'b0;
        if (a_r == b_r) begin
          res_cnt_r  <= 7'd0;
          res_root_r <= 1'b0;
        end else if (found_r) begin
          res_cnt_r  <= sat7(count_r);
          res_root_r <= 1'b0;
        end else begin
          res_cnt_r  <= (chain_sum == '0) ? 7'd0 : sat7(chain_sum - 1'b1);
          res_root_r <= 1'b1;
        end
      end
      tlpl_pkg::RES_ERR: begin
        res_cnt_r  <= 7'd0;
        res_root_r <= 1'b0;
        res_err_r  <= 1'b1;
      end
      default: begin
      end
    endcase
    if (uw.out_ld && out_free) begin
      out_tdata_r <= {res_root_r, res_cnt_r};
      out_tuser_r <= res_err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* src/tlpl_ram.sv */
module tlpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
